// ===== src/rhf_pkg.sv =====
// Shared constants, types and codes for the rectangle hash Fenwick block.
`default_nettype none

package rhf_pkg;

  localparam int ROWS = 256;
  localparam int COLS = 256;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = ROWS * COLS;
  localparam int CELL_W = 64;

  localparam int COORD_W = 9;
  localparam int IDX_W = COORD_W + 1;
  localparam int SIZE_W = 9;
  localparam int COEF_W = 30;
  localparam int NUM_TERMS = 4;
  localparam int TERM_W = $clog2(NUM_TERMS);
  localparam int PROD_W = COEF_W + COORD_W;
  localparam int RED_STEPS = 4;
  localparam int STEP_W = $clog2(RED_STEPS);
  localparam int WEIGHT_W = COEF_W + TERM_W;
  localparam logic [COEF_W-1:0] HASH_MOD = 30'd998244353;
  // Three folds by 2^30 mod P bring a product below 2P; one subtraction finishes it.
  localparam logic [COEF_W-1:0] FOLD_K = 30'd75497471;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_COMPARE = 2'd2,
    OP_NONE    = 2'd3
  } rhf_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_FIRST_ROW = 3'd0,
    REG_COEF_FIRST_COL = 3'd1,
    REG_COEF_LAST_ROW  = 3'd2,
    REG_COEF_LAST_COL  = 3'd3,
    REG_ROWS_IN_USE    = 3'd4,
    REG_COLS_IN_USE    = 3'd5,
    REG_SPARE_6        = 3'd6,
    REG_SPARE_7        = 3'd7
  } rhf_reg_e;

  typedef logic [NUM_TERMS-1:0][COEF_W-1:0] rhf_coefs_t;
  typedef logic [NUM_TERMS-1:0][COORD_W-1:0] rhf_coords_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] weight;
  } rhf_wt_stat_t;

endpackage

`default_nettype wire

// ===== src/rhf_req_if.sv =====
// Request channel carrying one operation and its two corner points.
`default_nettype none

interface rhf_req_if import rhf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [COORD_W-1:0] first_row;
  logic [COORD_W-1:0] first_col;
  logic [COORD_W-1:0] second_row;
  logic [COORD_W-1:0] second_col;

  modport source (
    output valid, opcode, first_row, first_col, second_row, second_col,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_row, first_col, second_row, second_col,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/rhf_rsp_if.sv =====
// Response channel carrying the result of a compare request.
`default_nettype none

interface rhf_rsp_if import rhf_pkg::*; ();
  logic valid;
  logic ready;
  logic same_region;

  modport source (output valid, same_region, input ready);
  modport sink (input valid, same_region, output ready);
endinterface

`default_nettype wire

// ===== src/rhf_cfg_if.sv =====
// Configuration write channel carrying a register index and write data.
`default_nettype none

interface rhf_cfg_if import rhf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/rhf_weight.sv =====
// Sequential weight unit: four coefficient products, each reduced modulo P, summed.
`default_nettype none

module rhf_weight import rhf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire rhf_coefs_t   coefs,
  input  wire rhf_coords_t  coords,
  output rhf_wt_stat_t      stat
);

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_MUL  = 3'b010,
    W_RED  = 3'b100
  } wstate_t;

  wstate_t             state;
  logic [TERM_W-1:0]   term;
  logic [STEP_W-1:0]   step;
  rhf_coords_t         crd;
  logic [PROD_W-1:0]   rem;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   fold_hi;
  logic [PROD_W-1:0]   fold;
  logic [WEIGHT_W-1:0] acc;
  logic                done;
  logic [PROD_W-1:0]   rem_next;

  assign prod     = PROD_W'(coefs[term]) * PROD_W'(crd[term]);
  assign fold_hi  = PROD_W'(rem[PROD_W-1:COEF_W]) * PROD_W'(FOLD_K);
  assign fold     = fold_hi + PROD_W'(rem[COEF_W-1:0]);
  assign rem_next = (step != '0) ? fold :
                    (rem >= PROD_W'(HASH_MOD)) ? rem - PROD_W'(HASH_MOD) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            crd   <= coords;
            term  <= '0;
            acc   <= '0;
            state <= W_MUL;
          end
        end
        W_MUL: begin
          rem   <= prod;
          step  <= STEP_W'(RED_STEPS - 1);
          state <= W_RED;
        end
        W_RED: begin
          rem <= rem_next;
          if (step == '0) begin
            acc <= acc + WEIGHT_W'(rem_next[COEF_W-1:0]);
            if (term == TERM_W'(NUM_TERMS - 1)) begin
              done  <= 1'b1;
              state <= W_IDLE;
            end else begin
              term  <= term + 1'b1;
              state <= W_MUL;
            end
          end else begin
            step <= step - 1'b1;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  assign stat.done   = done;
  assign stat.weight = acc;

endmodule

`default_nettype wire

// ===== src/rect_hash_fenwick_2d.sv =====
// Top level: two-dimensional Fenwick tree with hashed rectangle weights.
//
// The req channel takes add, remove and compare requests; a compare returns
// one response on the rsp channel, add and remove return nothing. The cfg
// channel writes the coefficient and size registers and is always ready.
// After reset the block sweeps the 65536-entry cell memory to zero, one entry
// a cycle, and holds req.ready low until the sweep is done.
// One request is worked at a time; the cell memory has one port, so every
// tree node is worked as a read, then a write back or an accumulate.
// For an add or remove the weight is built per term from one multiply, three
// folding steps and a final subtract; each corner is then taken in turn and
// up to 4 x 9 x 9 tree nodes are visited. A compare takes each point in turn
// and visits up to 2 x 8 x 8 nodes over the two prefix sums, then posts the
// response.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is already accepted, and only a compare that
// finishes behind a still-waiting response waits for it to drain.
`default_nettype none

module rect_hash_fenwick_2d import rhf_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  rhf_req_if.sink    req,
  rhf_rsp_if.source  rsp,
  rhf_cfg_if.sink    cfg
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_WEIGHT  = 10'b0000000100,
    S_UCORNER = 10'b0000001000,
    S_URD     = 10'b0000010000,
    S_UWR     = 10'b0000100000,
    S_QPOINT  = 10'b0001000000,
    S_QRD     = 10'b0010000000,
    S_QACC    = 10'b0100000000,
    S_RESP    = 10'b1000000000
  } state_t;

  function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
    return v & (~v + 1'b1);
  endfunction

  state_t              state;
  rhf_coefs_t          coefs;
  logic [SIZE_W-1:0]   rows_in_use;
  logic [SIZE_W-1:0]   cols_in_use;
  logic [1:0]          op;
  logic [COORD_W-1:0]  r1, c1, r2, c2;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [1:0]          cidx;
  logic                qsel;
  logic [IDX_W-1:0]    x, y, ybase;
  logic [CELL_W-1:0]   w64;
  logic [CELL_W-1:0]   acc;
  logic [CELL_W-1:0]   sum_first;
  logic                match;
  logic                rsp_valid;
  logic                rsp_same;

  logic [CELL_W-1:0]   mem [DEPTH];
  logic [CELL_W-1:0]   cell_rd;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [CELL_W-1:0]   mem_wdata;

  logic                req_fire;
  logic                w_start;
  rhf_coords_t         w_coords;
  rhf_wt_stat_t        wstat;

  logic [SIZE_W-1:0]   nr, nc;
  logic [IDX_W-1:0]    cr, cc;
  logic                corner_ok;
  logic [CELL_W-1:0]   pos_delta, delta;
  logic [COORD_W-1:0]  qr_raw, qc_raw, qr, qc;
  logic [IDX_W-1:0]    xm1, ym1;
  logic [IDX_W-1:0]    y_up, x_up, y_dn, x_dn;
  logic [CELL_W-1:0]   acc_new;
  logic                pt_fin;
  logic [CELL_W-1:0]   pt_sum;
  logic                rsp_load;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign w_start   = req_fire &&
                     (req.opcode == OP_ADD || req.opcode == OP_REMOVE);
  assign w_coords  = {req.second_col, req.second_row, req.first_col, req.first_row};

  rhf_weight u_weight (
    .clk    (clk),
    .rst    (rst),
    .start  (w_start),
    .coefs  (coefs),
    .coords (w_coords),
    .stat   (wstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs[0]    <= COEF_W'(1);
      coefs[1]    <= COEF_W'(2);
      coefs[2]    <= COEF_W'(3);
      coefs[3]    <= COEF_W'(4);
      rows_in_use <= SIZE_W'(256);
      cols_in_use <= SIZE_W'(256);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_COEF_FIRST_ROW: coefs[0] <= cfg.data[COEF_W-1:0];
        REG_COEF_FIRST_COL: coefs[1] <= cfg.data[COEF_W-1:0];
        REG_COEF_LAST_ROW:  coefs[2] <= cfg.data[COEF_W-1:0];
        REG_COEF_LAST_COL:  coefs[3] <= cfg.data[COEF_W-1:0];
        REG_ROWS_IN_USE:    rows_in_use <= cfg.data[SIZE_W-1:0];
        REG_COLS_IN_USE:    cols_in_use <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_in_use == '0) begin
      nr = SIZE_W'(1);
    end else if (rows_in_use > SIZE_W'(ROWS)) begin
      nr = SIZE_W'(ROWS);
    end else begin
      nr = rows_in_use;
    end
    if (cols_in_use == '0) begin
      nc = SIZE_W'(1);
    end else if (cols_in_use > SIZE_W'(COLS)) begin
      nc = SIZE_W'(COLS);
    end else begin
      nc = cols_in_use;
    end
  end

  always_comb begin
    case (cidx)
      2'd1: begin
        cr = IDX_W'(r1);
        cc = IDX_W'(c2) + 1'b1;
      end
      2'd2: begin
        cr = IDX_W'(r2) + 1'b1;
        cc = IDX_W'(c1);
      end
      2'd3: begin
        cr = IDX_W'(r2) + 1'b1;
        cc = IDX_W'(c2) + 1'b1;
      end
      default: begin
        cr = IDX_W'(r1);
        cc = IDX_W'(c1);
      end
    endcase
    corner_ok = (cr != '0) && (cc != '0) &&
                (cr <= IDX_W'(nr)) && (cc <= IDX_W'(nc));
    pos_delta = (op == OP_REMOVE) ? (~w64 + 1'b1) : w64;
    delta     = (cidx == 2'd0 || cidx == 2'd3) ? pos_delta : (~pos_delta + 1'b1);
  end

  always_comb begin
    qr_raw = qsel ? r2 : r1;
    qc_raw = qsel ? c2 : c1;
    qr     = (qr_raw > COORD_W'(nr)) ? COORD_W'(nr) : qr_raw;
    qc     = (qc_raw > COORD_W'(nc)) ? COORD_W'(nc) : qc_raw;
  end

  assign xm1     = x - 1'b1;
  assign ym1     = y - 1'b1;
  assign y_up    = y + low_bit(y);
  assign x_up    = x + low_bit(x);
  assign y_dn    = y - low_bit(y);
  assign x_dn    = x - low_bit(x);
  assign acc_new = acc + cell_rd;

  always_comb begin
    pt_fin = 1'b0;
    pt_sum = acc_new;
    case (state)
      S_QPOINT: begin
        if (qr == '0 || qc == '0) begin
          pt_fin = 1'b1;
          pt_sum = '0;
        end
      end
      S_QACC: pt_fin = (y_dn == '0) && (x_dn == '0);
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_UWR);
    mem_addr  = (state == S_CLEAR) ? clr_cnt : {xm1[ROW_W-1:0], ym1[COL_W-1:0]};
    mem_wdata = (state == S_CLEAR) ? '0 : cell_rd + delta;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    cell_rd <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      cidx    <= '0;
      qsel    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            op <= req.opcode;
            r1 <= req.first_row;
            c1 <= req.first_col;
            r2 <= req.second_row;
            c2 <= req.second_col;
            case (req.opcode)
              OP_ADD, OP_REMOVE: state <= S_WEIGHT;
              OP_COMPARE: begin
                qsel  <= 1'b0;
                state <= S_QPOINT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_WEIGHT: begin
          if (wstat.done) begin
            w64   <= CELL_W'(wstat.weight);
            cidx  <= '0;
            state <= S_UCORNER;
          end
        end
        S_UCORNER: begin
          if (corner_ok) begin
            x     <= cr;
            y     <= cc;
            ybase <= cc;
            state <= S_URD;
          end else if (cidx == 2'd3) begin
            state <= S_IDLE;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_URD: state <= S_UWR;
        S_UWR: begin
          if (y_up <= IDX_W'(nc)) begin
            y     <= y_up;
            state <= S_URD;
          end else if (x_up <= IDX_W'(nr)) begin
            x     <= x_up;
            y     <= ybase;
            state <= S_URD;
          end else if (cidx == 2'd3) begin
            state <= S_IDLE;
          end else begin
            cidx  <= cidx + 1'b1;
            state <= S_UCORNER;
          end
        end
        S_QPOINT: begin
          if (!pt_fin) begin
            x     <= IDX_W'(qr);
            y     <= IDX_W'(qc);
            ybase <= IDX_W'(qc);
            acc   <= '0;
            state <= S_QRD;
          end
        end
        S_QRD: state <= S_QACC;
        S_QACC: begin
          acc <= acc_new;
          if (y_dn != '0) begin
            y     <= y_dn;
            state <= S_QRD;
          end else if (x_dn != '0) begin
            x     <= x_dn;
            y     <= ybase;
            state <= S_QRD;
          end
        end
        S_RESP: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (pt_fin) begin
        if (!qsel) begin
          sum_first <= pt_sum;
          qsel      <= 1'b1;
          state     <= S_QPOINT;
        end else begin
          match <= (sum_first == pt_sum);
          state <= S_RESP;
        end
      end
    end
  end

  assign rsp_load = (state == S_RESP) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_same <= match;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.same_region = rsp_same;

  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during the clearing sweep");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_QRD || state == S_QACC || state == S_QPOINT) |-> !mem_we)
    else $error("cell memory written during a compare");

  a_weight_done_state: assert property (@(posedge clk) disable iff (rst)
    wstat.done |-> (state == S_WEIGHT))
    else $error("weight finished outside the weight phase");

  a_update_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UWR) |-> (x != '0 && y != '0 &&
                          x <= IDX_W'(nr) && y <= IDX_W'(nc)))
    else $error("tree update outside the grid in use");

endmodule

`default_nettype wire
